// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros: assertion helpers for the sort block checkers
// Clocked properties with a synchronous reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge out of reset
`define CHK_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (prop)) else $error(msg);

// expression must never be true out of reset
`define CHK_NEVER(lbl, ck, rs, expr, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) !(expr)) else $error(msg);

`endif

// ===== hw/rtl/rsl_pkg.sv =====
// ----------------------------------------------------------------------------
// rsl_pkg
// Types and constants for the base-10 LSD radix sort block.
// ----------------------------------------------------------------------------
package rsl_pkg;

  typedef struct packed {
    logic signed [31:0] value;
    logic               last;
  } req_t;

  typedef struct packed {
    logic [30:0] sorted_value;
    logic        last_res;
    logic [1:0]  status;
  } res_t;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NEGATIVE = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

  localparam int          KEY_W      = 31;
  localparam int          RADIX      = 10;
  localparam logic [31:0] RECIP_10   = 32'hCCCC_CCCD;
  localparam logic [3:0]  LAST_DIGIT = 4'd9;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HCLR,
    ST_HRD,
    ST_HWAIT,
    ST_HMUL,
    ST_HUSE,
    ST_PSUM,
    ST_SRD,
    ST_SWAIT,
    ST_SMUL,
    ST_SUSE,
    ST_TMUL,
    ST_TUSE,
    ST_ERD,
    ST_EOUT,
    ST_ERR
  } state_t;

endpackage

// ===== hw/rtl/rsl_ram.sv =====
// ----------------------------------------------------------------------------
// rsl_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rsl_ram #(
  parameter int WIDTH = 62,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/radix_sort_lsd_base10.sv =====
// ----------------------------------------------------------------------------
// radix_sort_lsd_base10
// Collects keys, sorts them by base-10 LSD radix sort, streams them out.
// ----------------------------------------------------------------------------
//  channel  | ports                  | handshake
//  ---------+------------------------+-------------------------------
//  request  | req (value, last)      | taken when start && !busy
//  result   | res (value, last, st)  | one cycle, marked by res_valid
//
//  Keys load one per cycle. After the last key each digit pass clears the
//  histogram, counts digits, sums prefixes and scatters keys to the other
//  bank, for as many passes as the largest key has digits; all use one
//  shared multiply-by-reciprocal divide-by-ten unit; keys leave in turn.
//  Reset is synchronous and returns the block to idle with an empty buffer.
//  The receiver cannot stall; busy stays high until the last result.
// ----------------------------------------------------------------------------
module radix_sort_lsd_base10 #(
  parameter int MAX_KEYS = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  rsl_pkg::req_t req,
  output logic          res_valid,
  output rsl_pkg::res_t res
);

  localparam int IW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int CW = $clog2(MAX_KEYS + 1);
  localparam int KW = rsl_pkg::KEY_W;
  localparam int DW = 2 * KW;
  localparam int AW = IW + 1;

  rsl_pkg::state_t state, state_next;

  logic [CW-1:0] count;
  logic [CW-1:0] counts [rsl_pkg::RADIX];
  logic [IW-1:0] idx;
  logic [3:0]    j;
  logic          bank;
  logic          neg;
  logic          ovf;
  logic [KW-1:0] topq;
  logic [KW-1:0] mop;
  logic [KW-1:0] rkey;
  logic [63:0]   prod;

  logic          we;
  logic [AW-1:0] waddr;
  logic [DW-1:0] wdata;
  logic [DW-1:0] rdata;

  logic          accept;
  logic          store;
  logic [KW-1:0] q10;
  logic [3:0]    dig;
  logic [3:0]    lo4;
  logic [CW-1:0] pos;
  logic          idx_end;
  logic [KW-1:0] top_new;

  assign accept  = start && !busy;
  assign store   = accept && !req.value[31] && (count != CW'(MAX_KEYS));
  assign q10     = {2'b00, prod[63:35]};
  assign lo4     = {q10[0], 3'b000} + {q10[2:0], 1'b0};
  assign dig     = mop[3:0] - lo4;
  assign pos     = counts[dig] - CW'(1);
  assign idx_end = (CW'(idx) == (count - CW'(1)));
  assign top_new = (req.value[30:0] > topq) ? req.value[30:0] : topq;

  always_comb begin
    we    = 1'b0;
    waddr = {bank, count[IW-1:0]};
    wdata = {req.value[30:0], req.value[30:0]};
    if (state == rsl_pkg::ST_IDLE) begin
      we = store;
    end else if (state == rsl_pkg::ST_SUSE) begin
      we    = 1'b1;
      waddr = {~bank, pos[IW-1:0]};
      wdata = {q10, rkey};
    end
  end

  rsl_ram #(
    .WIDTH(DW),
    .DEPTH(2 ** AW)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr({bank, idx}),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rsl_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    busy       = (state != rsl_pkg::ST_IDLE);
    res_valid  = 1'b0;
    res        = '0;
    unique case (state)
      rsl_pkg::ST_IDLE: begin
        if (accept && req.last) begin
          if (neg || ovf || req.value[31] || (count == CW'(MAX_KEYS))) begin
            state_next = rsl_pkg::ST_ERR;
          end else if (top_new == '0) begin
            state_next = rsl_pkg::ST_ERD;
          end else begin
            state_next = rsl_pkg::ST_HCLR;
          end
        end
      end
      rsl_pkg::ST_HCLR:  state_next = rsl_pkg::ST_HRD;
      rsl_pkg::ST_HRD:   state_next = rsl_pkg::ST_HWAIT;
      rsl_pkg::ST_HWAIT: state_next = rsl_pkg::ST_HMUL;
      rsl_pkg::ST_HMUL:  state_next = rsl_pkg::ST_HUSE;
      rsl_pkg::ST_HUSE:  state_next = idx_end ? rsl_pkg::ST_PSUM : rsl_pkg::ST_HRD;
      rsl_pkg::ST_PSUM: begin
        if (j == rsl_pkg::LAST_DIGIT) begin
          state_next = rsl_pkg::ST_SRD;
        end
      end
      rsl_pkg::ST_SRD:   state_next = rsl_pkg::ST_SWAIT;
      rsl_pkg::ST_SWAIT: state_next = rsl_pkg::ST_SMUL;
      rsl_pkg::ST_SMUL:  state_next = rsl_pkg::ST_SUSE;
      rsl_pkg::ST_SUSE:  state_next = (idx == '0) ? rsl_pkg::ST_TMUL : rsl_pkg::ST_SRD;
      rsl_pkg::ST_TMUL:  state_next = rsl_pkg::ST_TUSE;
      rsl_pkg::ST_TUSE:  state_next = (q10 == '0) ? rsl_pkg::ST_ERD : rsl_pkg::ST_HCLR;
      rsl_pkg::ST_ERD:   state_next = rsl_pkg::ST_EOUT;
      rsl_pkg::ST_EOUT: begin
        res_valid        = 1'b1;
        res.sorted_value = rdata[KW-1:0];
        res.last_res     = idx_end;
        res.status       = rsl_pkg::STATUS_OK;
        state_next       = idx_end ? rsl_pkg::ST_IDLE : rsl_pkg::ST_ERD;
      end
      rsl_pkg::ST_ERR: begin
        res_valid        = 1'b1;
        res.sorted_value = '0;
        res.last_res     = 1'b1;
        res.status       = neg ? rsl_pkg::STATUS_NEGATIVE : rsl_pkg::STATUS_OVERFLOW;
        state_next       = rsl_pkg::ST_IDLE;
      end
      default: state_next = rsl_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      neg   <= 1'b0;
      ovf   <= 1'b0;
      topq  <= '0;
      bank  <= 1'b0;
      idx   <= '0;
      j     <= '0;
      for (int k = 0; k < rsl_pkg::RADIX; k++) begin
        counts[k] <= '0;
      end
    end else begin
      case (state) inside
        rsl_pkg::ST_IDLE: begin
          idx <= '0;
          if (accept) begin
            if (req.value[31]) begin
              neg <= 1'b1;
            end else if (count == CW'(MAX_KEYS)) begin
              ovf <= 1'b1;
            end else begin
              count <= count + CW'(1);
              topq  <= top_new;
            end
          end
        end
        rsl_pkg::ST_HCLR: begin
          idx <= '0;
          for (int k = 0; k < rsl_pkg::RADIX; k++) begin
            counts[k] <= '0;
          end
        end
        rsl_pkg::ST_HWAIT, rsl_pkg::ST_SWAIT: begin
          mop  <= rdata[DW-1:KW];
          rkey <= rdata[KW-1:0];
        end
        rsl_pkg::ST_HMUL, rsl_pkg::ST_SMUL, rsl_pkg::ST_TMUL: begin
          prod <= {1'b0, mop} * rsl_pkg::RECIP_10;
        end
        rsl_pkg::ST_HUSE: begin
          counts[dig] <= counts[dig] + CW'(1);
          idx         <= idx + IW'(1);
          j           <= 4'd1;
        end
        rsl_pkg::ST_PSUM: begin
          counts[j] <= counts[j] + counts[j - 4'd1];
          j         <= j + 4'd1;
          idx       <= IW'(count - CW'(1));
        end
        rsl_pkg::ST_SUSE: begin
          counts[dig] <= pos;
          idx         <= idx - IW'(1);
          mop         <= topq;
        end
        rsl_pkg::ST_TUSE: begin
          topq <= q10;
          bank <= ~bank;
          idx  <= '0;
        end
        rsl_pkg::ST_EOUT: begin
          idx <= idx + IW'(1);
          if (idx_end) begin
            count <= '0;
            topq  <= '0;
            idx   <= '0;
          end
        end
        rsl_pkg::ST_ERR: begin
          count <= '0;
          neg   <= 1'b0;
          ovf   <= 1'b0;
          topq  <= '0;
          idx   <= '0;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/rsl_checker.sv =====
// ----------------------------------------------------------------------------
// rsl_checker
// Port-level checks for the radix sort block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rsl_checker (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input rsl_pkg::req_t req,
  input logic          res_valid,
  input rsl_pkg::res_t res
);

  logic load_plain;
  logic load_last;
  logic err_res;
  logic err_ok;

  assign load_plain = start && !busy && !req.last;
  assign load_last  = start && !busy && req.last;
  assign err_res    = res_valid && (res.status != rsl_pkg::STATUS_OK);
  assign err_ok     = res.last_res && (res.sorted_value == '0);

  `CHK_NEVER(a_res_idle, clk, rst, res_valid && !busy, "result while idle")
  `CHK_ASSERT(a_err_last, clk, rst, err_res |-> err_ok, "error result malformed")
  `CHK_ASSERT(a_load_idle, clk, rst, load_plain |=> !busy, "busy after plain load")
  `CHK_ASSERT(a_last_done, clk, rst, (res_valid && res.last_res) |=> !busy, "busy after final")
  `CHK_ASSERT(a_run_start, clk, rst, load_last |=> busy, "final request not taken")

endmodule

bind radix_sort_lsd_base10 rsl_checker u_rsl_checker (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .req      (req),
  .res_valid(res_valid),
  .res      (res)
);
